// ----- rtl/rqa_pkg.sv -----
// Package for the ring queue with averaging: field widths, defaults,
// operation codes, sequencer states and the word structs of both channels.
// Used by the top level and the checker; depends on nothing.
package rqa_pkg;

    localparam int DATA_W      = 16;
    localparam int COUNT_W     = 8;
    localparam int CFG_W       = 9;
    localparam int DEPTH_DEF   = 256;
    localparam int WIDTH_DEF   = 16;

    // Operation codes carried in the input word.
    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_AVG   = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    // Sequencer states of the top level.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POP,
        ST_SUM,
        ST_DIV,
        ST_FIN
    } t_state;

    typedef struct packed {
        t_op               op;
        logic [DATA_W-1:0] value;
    } t_in_word;

    typedef struct packed {
        logic               ok;
        logic [DATA_W-1:0]  data;
        logic [COUNT_W-1:0] count;
        logic               is_empty;
        logic               is_full;
    } t_out_word;

endpackage

// ----- rtl/ring_queue_with_average.sv -----
// Top level of the ring queue with averaging: sequencer, indices, shared adder
// and output register. Depends on rqa_pkg and instantiates rqa_ram.
//
// A circular queue of DEPTH slots whose modulus is set by the one configuration
// register (clamped to 2..DEPTH); it holds up to modulus minus one samples, and
// writing the register also empties the queue. Each input word is push, pop,
// average or clear and yields exactly one output word. Push, clear and any
// refused operation finish in the idle state; pop waits in ST_POP for the
// registered read of the slot memory. Average of n held samples walks the n
// slots in ST_SUM, one slot read per cycle through the shared adder, then one
// quotient bit per cycle of a restoring division on that same adder (ST_DIV).
// The slot memory is not cleared after reset; no slot's data is used before it is written.
module ring_queue_with_average #(
    parameter int DEPTH = rqa_pkg::DEPTH_DEF,
    parameter int WIDTH = rqa_pkg::WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  rqa_pkg::t_in_word          i_in,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output rqa_pkg::t_out_word         o_out,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [rqa_pkg::CFG_W-1:0]  i_cfg_data
);

    localparam int IW   = $clog2(DEPTH);
    localparam int SW   = $clog2(DEPTH + 1);
    localparam int SUMW = WIDTH + IW;
    localparam int ALUW = SUMW + 1;
    localparam int BW   = $clog2(SUMW + 1);
    localparam int CFG_W_L = rqa_pkg::CFG_W;

    rqa_pkg::t_state r_state, n_state;
    logic [IW-1:0]   r_head, n_head;
    logic [IW-1:0]   r_tail, n_tail;
    logic [SW-1:0]   r_size, n_size;
    logic [IW-1:0]   r_ptr, n_ptr;
    logic [IW-1:0]   r_left, n_left;
    logic [IW-1:0]   r_div, n_div;
    logic [IW-1:0]   r_rem, n_rem;
    logic [SUMW-1:0] r_acc, n_acc;
    logic [BW-1:0]   r_bits, n_bits;
    logic            r_out_valid, n_out_valid;
    rqa_pkg::t_out_word r_out;

    logic             ram_we;
    logic [IW-1:0]    ram_raddr;
    logic [WIDTH-1:0] ram_rdata;

    logic [ALUW-1:0]  alu_a, alu_b, alu_y;
    logic             alu_sub;

    logic             out_free, in_acc, cfg_acc;
    logic             empty_now, full_now;
    logic [IW-1:0]    count_now;
    logic             out_load, ld_ok;
    logic [rqa_pkg::DATA_W-1:0] ld_data;
    logic [IW:0]      shifted;
    logic [CFG_W_L-1:0] cfg_clamped;

    // Next slot index around the ring of the current modulus.
    function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] idx,
                                                input logic [SW-1:0] size);
        logic [SW-1:0] nx;
        nx = SW'(idx) + SW'(1);
        return (nx >= size) ? '0 : nx[IW-1:0];
    endfunction

    // Number of entries held between head and tail.
    function automatic logic [IW-1:0] ring_count(input logic [IW-1:0] h,
                                                 input logic [IW-1:0] t,
                                                 input logic [SW-1:0] size);
        logic [SW-1:0] d;
        if (t >= h) begin
            d = SW'(t) - SW'(h);
        end else begin
            d = SW'(t) + size - SW'(h);
        end
        return d[IW-1:0];
    endfunction

    rqa_ram #(
        .WIDTH(WIDTH),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_tail),
        .i_wdata(i_in.value[WIDTH-1:0]),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // Handshake conditions.
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_cfg_ready = (r_state == rqa_pkg::ST_IDLE);
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign o_in_stall  = !((r_state == rqa_pkg::ST_IDLE) && out_free && !i_cfg_valid);
    assign in_acc      = i_in_valid && !o_in_stall;

    // Status of the ring before the current operation.
    assign empty_now = (r_head == r_tail);
    assign full_now  = (ring_next(r_tail, r_size) == r_head);
    assign count_now = ring_count(r_head, r_tail, r_size);

    // The walk reads the pointer; everything else reads at the head.
    assign ram_raddr = (r_state == rqa_pkg::ST_SUM) ? r_ptr : r_head;

    // Clamp a written modulus into the supported range.
    always_comb begin
        priority if (i_cfg_data < CFG_W_L'(2)) begin
            cfg_clamped = CFG_W_L'(2);
        end else if (int'(i_cfg_data) > DEPTH) begin
            cfg_clamped = CFG_W_L'(DEPTH);
        end else begin
            cfg_clamped = i_cfg_data;
        end
    end

    // Shared adder: accumulates samples, then does the division steps.
    assign shifted = {r_rem, r_acc[SUMW-1]};
    always_comb begin
        if (r_state == rqa_pkg::ST_DIV) begin
            alu_a   = ALUW'(shifted);
            alu_b   = ALUW'(r_div);
            alu_sub = 1'b1;
        end else begin
            alu_a   = ALUW'(r_acc);
            alu_b   = ALUW'(ram_rdata);
            alu_sub = 1'b0;
        end
        alu_y = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
    end

    // Sequencer: next state, index updates and output loading.
    always_comb begin
        n_state  = r_state;
        n_head   = r_head;
        n_tail   = r_tail;
        n_size   = r_size;
        n_ptr    = r_ptr;
        n_left   = r_left;
        n_div    = r_div;
        n_rem    = r_rem;
        n_acc    = r_acc;
        n_bits   = r_bits;
        ram_we   = 1'b0;
        out_load = 1'b0;
        ld_ok    = 1'b0;
        ld_data  = '0;

        unique case (r_state)
            rqa_pkg::ST_IDLE: begin
                priority if (cfg_acc) begin
                    n_size = cfg_clamped[SW-1:0];
                    n_head = '0;
                    n_tail = '0;
                end else if (in_acc) begin
                    unique case (i_in.op)
                        rqa_pkg::OP_PUSH: begin
                            out_load = 1'b1;
                            if (!full_now) begin
                                ram_we = 1'b1;
                                n_tail = ring_next(r_tail, r_size);
                                ld_ok  = 1'b1;
                            end
                        end
                        rqa_pkg::OP_POP: begin
                            if (empty_now) begin
                                out_load = 1'b1;
                            end else begin
                                n_state = rqa_pkg::ST_POP;
                            end
                        end
                        rqa_pkg::OP_AVG: begin
                            if (empty_now) begin
                                out_load = 1'b1;
                            end else begin
                                n_ptr   = ring_next(r_head, r_size);
                                n_acc   = '0;
                                n_left  = count_now;
                                n_div   = count_now;
                                n_state = rqa_pkg::ST_SUM;
                            end
                        end
                        rqa_pkg::OP_CLEAR: begin
                            n_head   = '0;
                            n_tail   = '0;
                            ld_ok    = 1'b1;
                            out_load = 1'b1;
                        end
                    endcase
                end
            end
            rqa_pkg::ST_POP: begin
                if (out_free) begin
                    ld_ok    = 1'b1;
                    ld_data  = rqa_pkg::DATA_W'(ram_rdata);
                    n_head   = ring_next(r_head, r_size);
                    out_load = 1'b1;
                    n_state  = rqa_pkg::ST_IDLE;
                end
            end
            rqa_pkg::ST_SUM: begin
                n_acc  = alu_y[SUMW-1:0];
                n_ptr  = ring_next(r_ptr, r_size);
                n_left = r_left - IW'(1);
                if (r_left == IW'(1)) begin
                    n_rem   = '0;
                    n_bits  = BW'(SUMW);
                    n_state = rqa_pkg::ST_DIV;
                end
            end
            rqa_pkg::ST_DIV: begin
                // Restoring step: keep the difference when it does not borrow.
                if (!alu_y[ALUW-1]) begin
                    n_rem = alu_y[IW-1:0];
                    n_acc = {r_acc[SUMW-2:0], 1'b1};
                end else begin
                    n_rem = shifted[IW-1:0];
                    n_acc = {r_acc[SUMW-2:0], 1'b0};
                end
                n_bits = r_bits - BW'(1);
                if (r_bits == BW'(1)) begin
                    n_state = rqa_pkg::ST_FIN;
                end
            end
            rqa_pkg::ST_FIN: begin
                if (out_free) begin
                    ld_ok    = 1'b1;
                    ld_data  = rqa_pkg::DATA_W'(r_acc[WIDTH-1:0]);
                    out_load = 1'b1;
                    n_state  = rqa_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rqa_pkg::ST_IDLE;
            end
        endcase

        n_out_valid = out_load ? 1'b1 : (r_out_valid && i_out_stall);
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rqa_pkg::ST_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_size      <= SW'(DEPTH);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_size      <= n_size;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers and the output word, with status after the operation.
    always_ff @(posedge i_clk) begin
        r_ptr  <= n_ptr;
        r_left <= n_left;
        r_div  <= n_div;
        r_rem  <= n_rem;
        r_acc  <= n_acc;
        r_bits <= n_bits;
        if (out_load) begin
            r_out.ok       <= ld_ok;
            r_out.data     <= ld_data;
            r_out.count    <= rqa_pkg::COUNT_W'(ring_count(n_head, n_tail, r_size));
            r_out.is_empty <= (n_head == n_tail);
            r_out.is_full  <= (ring_next(n_tail, r_size) == n_head);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ----- rtl/rqa_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Used by the ring queue for its sample slots; depends on nothing.
module rqa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [$clog2(DEPTH)-1:0]      i_waddr,
    input  logic [WIDTH-1:0]              i_wdata,
    input  logic [$clog2(DEPTH)-1:0]      i_raddr,
    output logic [WIDTH-1:0]              o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/rqa_checker.sv -----
// Port-level checker for the ring queue with averaging, and its bind.
// Depends on rqa_pkg; attaches to ring_queue_with_average.
module rqa_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_stall,
    input rqa_pkg::t_in_word          i_in,
    input logic                       o_out_valid,
    input logic                       i_out_stall,
    input rqa_pkg::t_out_word         o_out,
    input logic                       i_cfg_valid,
    input logic                       o_cfg_ready,
    input logic [rqa_pkg::CFG_W-1:0]  i_cfg_data
);

    // A stalled result word stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("output word dropped while stalled");

    // A stalled result word keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(o_out))
        else $error("output word changed while stalled");

    // The empty flag agrees with the count.
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.is_empty == (o_out.count == '0)))
        else $error("empty flag disagrees with count");

    // One slot stays unused, so a full ring is never empty.
    a_full_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.is_full) |-> !o_out.is_empty)
        else $error("full and empty at once");

    // A refused operation returns zero data.
    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.ok) |-> (o_out.data == '0))
        else $error("refused operation returned data");

endmodule

bind ring_queue_with_average rqa_checker u_rqa_checker (.*);
